// ===== rtl/core/irs_pkg.sv =====
// Shared types, constants and functions of the integer to radix string converter.
package irs_pkg;

    localparam int VALUE_BITS    = 63;
    localparam int TDATA_IN_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int CHAR_BITS     = 7;
    localparam int TDATA_OUT_BITS = ((CHAR_BITS + 7) / 8) * 8;
    localparam int BASE_BITS     = 6;
    localparam int STORE_DEPTH   = 64;
    localparam int IDX_BITS      = $clog2(STORE_DEPTH);
    localparam int CNT_BITS      = IDX_BITS + 1;
    localparam int DIV_CNT_BITS  = $clog2(VALUE_BITS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 2;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_RADIX = 2'd0;
    localparam logic [BASE_BITS-1:0]     RADIX_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0]     BASE_MIN = 6'd2;
    localparam logic [BASE_BITS-1:0]     BASE_MAX = 6'd62;
    localparam logic [CHAR_BITS-1:0]     CHAR_ZERO = 7'd48;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [BASE_BITS-1:0]  base;
    } t_job;

    typedef struct packed {
        logic                 start;
        logic [BASE_BITS-1:0] base;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_READ,
        BK_LOAD
    } t_back_state;

    // Radix codes below two or above sixty-two saturate into the legal range.
    function automatic logic [BASE_BITS-1:0] eff_base(input logic [BASE_BITS-1:0] r);
        logic [BASE_BITS-1:0] b;
        b = r;
        if (r < BASE_MIN) b = BASE_MIN;
        if (r > BASE_MAX) b = BASE_MAX;
        return b;
    endfunction

    // Maps a digit value onto 0-9, A-Z, a-z.
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [BASE_BITS-1:0] d);
        logic [BASE_BITS-1:0] v;
        logic [CHAR_BITS-1:0] c;
        v = (d > 6'd61) ? 6'd61 : d;
        if (v < 6'd10) begin
            c = CHAR_ZERO + CHAR_BITS'(v);
        end else if (v < 6'd36) begin
            c = 7'd55 + CHAR_BITS'(v);
        end else begin
            c = 7'd61 + CHAR_BITS'(v);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/irs_front.sv =====
// Input side: accepts values, attaches the saturated base and queues the jobs.
module irs_front import irs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [BASE_BITS-1:0]     i_radix,
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic [VALUE_BITS-1:0]    i_s_value,
    output logic                     o_q_valid,
    output t_job                     o_q_job,
    input  logic                     i_q_pop
);

    t_job                 r_ent [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 push;
    logic                 pop;

    assign o_s_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign push      = i_s_valid && o_s_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_job   = r_ent[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= '{value: i_s_value, base: eff_base(i_radix)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/irs_divider.sv =====
// Restoring divider of a value by a small base, one quotient bit per cycle.
module irs_divider import irs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_ctl              i_ctl,
    input  logic [VALUE_BITS-1:0] i_dividend,
    output t_div_stat             o_stat,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [BASE_BITS-1:0]  o_remainder
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [VALUE_BITS-1:0]   r_q;
    logic [BASE_BITS-1:0]    r_rem;
    logic [BASE_BITS-1:0]    r_base;
    logic [BASE_BITS:0]      trial;
    logic [BASE_BITS:0]      diff;
    logic                    ge;

    assign trial = {r_rem, r_q[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_base};
    assign ge    = (trial >= {1'b0, r_base});

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_base <= i_ctl.base;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_BITS-2:0], ge};
            r_rem <= ge ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat      = '{busy: r_busy, done: r_done};
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/core/irs_back.sv =====
// Work side: divides a job into digits, stores them and emits them top digit first.
module irs_back import irs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_job                 i_q_job,
    output logic                 o_q_pop,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output logic [CHAR_BITS-1:0] o_m_char,
    output logic                 o_m_last
);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [VALUE_BITS-1:0] r_quot;
    logic [BASE_BITS-1:0]  r_base;
    logic [CNT_BITS-1:0]   r_n;
    logic [IDX_BITS-1:0]   r_rd_idx;
    logic [BASE_BITS-1:0]  r_rd_data;
    logic [BASE_BITS-1:0]  r_mem [STORE_DEPTH];
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char;
    logic                  r_out_last;

    t_div_ctl              div_ctl;
    t_div_stat             div_stat;
    logic [VALUE_BITS-1:0] div_quot;
    logic [BASE_BITS-1:0]  div_rem;
    logic                  stop;
    logic                  out_free;
    logic                  mem_we;
    logic                  mem_re;
    logic                  out_load;
    logic                  div_start;

    irs_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (r_quot),
        .o_stat      (div_stat),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    assign div_ctl  = '{start: div_start, base: r_base};
    assign stop     = (div_quot == '0) || ((r_n + 1'b1) == CNT_BITS'(STORE_DEPTH));
    assign out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:      if (i_q_valid) n_state = BK_DIV_START;
            BK_DIV_START: n_state = BK_DIV_WAIT;
            BK_DIV_WAIT: begin
                if (div_stat.done) n_state = stop ? BK_READ : BK_DIV_START;
            end
            BK_READ:      n_state = BK_LOAD;
            BK_LOAD: begin
                if (out_free) n_state = (r_rd_idx == '0) ? BK_IDLE : BK_READ;
            end
            default:      n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            BK_IDLE:      o_q_pop = i_q_valid;
            BK_DIV_START: div_start = 1'b1;
            BK_DIV_WAIT:  mem_we = div_stat.done;
            BK_READ:      mem_re = 1'b1;
            BK_LOAD:      out_load = out_free;
            default:      o_q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_n[IDX_BITS-1:0]] <= div_rem;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_quot <= i_q_job.value;
            r_base <= i_q_job.base;
        end else if (mem_we) begin
            r_quot <= div_quot;
            if (stop) r_rd_idx <= r_n[IDX_BITS-1:0];
        end else if (out_load) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (out_load) begin
            r_out_char <= digit_char(r_rd_data);
            r_out_last <= (r_rd_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_n <= '0;
            end else if (mem_we) begin
                r_n <= r_n + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_char  = r_out_char;
    assign o_m_last  = r_out_last;

endmodule

// ===== rtl/core/integer_to_radix_string.sv =====
// Top level of the integer to radix string converter.
//
// A beat on the slave stream carries one nonnegative integer in
// s_axis_tdata. The block writes it out as a string of ASCII digits in the
// base held in the radix register, most significant digit first, one
// character per master beat; tlast marks the final, least significant
// digit. A value of zero gives the single character '0'. The radix
// register (APB address 0) saturates codes below two to base two and
// codes above sixty-two to base sixty-two; the base is sampled when the
// value is accepted.
//
// Values enter a two-entry queue and are worked off one at a time. Each
// digit needs one pass of the shared bit-serial divider, started and
// awaited by control states; the digits are then read from the digit
// store and loaded into the output register one by one. While the
// receiver stalls, the output register holds its beat and the work stops
// at the next digit; the queue keeps taking values until it is full.
// Reset empties the queue, drops any string in progress and sets the
// radix to ten.
module integer_to_radix_string import irs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Slave stream; tdata: value [62:0], zero padding [63].
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [TDATA_IN_BITS-1:0]  s_axis_tdata,
    // Master stream; tdata: digit_char [6:0], zero padding [7].
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [TDATA_OUT_BITS-1:0] m_axis_tdata,
    output logic                      m_axis_tlast,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    logic [BASE_BITS-1:0] r_radix;
    logic                 q_valid;
    t_job                 q_job;
    logic                 q_pop;
    logic [CHAR_BITS-1:0] m_char;

    // The register takes the low six bits of the written word.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_RADIX)) begin
            r_radix <= pwdata[BASE_BITS-1:0];
        end
    end

    assign prdata = (paddr == ADDR_RADIX) ? APB_DATA_BITS'(r_radix) : '0;

    irs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_radix   (r_radix),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_value (s_axis_tdata[VALUE_BITS-1:0]),
        .o_q_valid (q_valid),
        .o_q_job   (q_job),
        .i_q_pop   (q_pop)
    );

    irs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_char  (m_char),
        .o_m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = TDATA_OUT_BITS'(m_char);

endmodule

// ===== rtl/core/irs_checker.sv =====
// Port-level checks of the integer to radix string converter, bound to the top level.
module irs_checker import irs_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [TDATA_OUT_BITS-1:0] m_axis_tdata,
    input logic                      m_axis_tlast,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [APB_ADDR_BITS-1:0]  paddr,
    input logic [APB_DATA_BITS-1:0]  pwdata,
    input logic [APB_DATA_BITS-1:0]  prdata
);

    // High while the next output beat opens a new string.
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_first <= m_axis_tlast;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[CHAR_BITS-1:0] >= CHAR_ZERO &&
                           m_axis_tdata[CHAR_BITS-1:0] <= 7'd122 &&
                           m_axis_tdata[TDATA_OUT_BITS-1:CHAR_BITS] == '0))
        else $error("output character outside the digit alphabet");

    a_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_first && m_axis_tdata[CHAR_BITS-1:0] == CHAR_ZERO) |->
        m_axis_tlast)
        else $error("string starts with a leading zero");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && paddr == ADDR_RADIX) |=>
        (paddr != ADDR_RADIX ||
         prdata == APB_DATA_BITS'($past(pwdata[BASE_BITS-1:0]))))
        else $error("radix readback differs from the written value");

endmodule

bind integer_to_radix_string irs_checker u_irs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the integer to radix string converter.
module tb_top;
    import irs_pkg::*;

    // Cycles without any stream beat before the run is declared hung. One
    // 63-digit binary string is fully divided before its first character
    // leaves, and a long receiver stall can add to the wait.
    localparam int HANG_LIMIT = 20000;
    // Quiet cycles allowed after the last expected character, to catch
    // stray beats.
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 15;

    // One expected output character and its end-of-string flag.
    typedef struct {
        logic [CHAR_BITS-1:0] ch;
        logic                 fin;
    } t_glyph;

    // Keeps a private copy of the radix register, spells each accepted
    // value in that base and checks the characters as they leave.
    class radix_scoreboard;
        logic [BASE_BITS-1:0] radix_copy;
        t_glyph               pending_glyphs[$];
        int                   errors;
        int                   values_seen;
        int                   chars_checked;

        function new();
            radix_copy    = RADIX_RESET;
            errors        = 0;
            values_seen   = 0;
            chars_checked = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        // Codes 0 and 1 act as base two; code 63 acts as base sixty-two.
        function logic [VALUE_BITS-1:0] base_in_use();
            if (radix_copy < BASE_MIN) return VALUE_BITS'(BASE_MIN);
            if (radix_copy > BASE_MAX) return VALUE_BITS'(BASE_MAX);
            return VALUE_BITS'(radix_copy);
        endfunction

        // Digit table: 0-9, then A-Z, then a-z.
        function logic [CHAR_BITS-1:0] glyph_of(logic [BASE_BITS-1:0] d);
            if (d < 6'd10) return CHAR_ZERO + CHAR_BITS'(d);
            if (d < 6'd36) return 7'd65 + CHAR_BITS'(d - 6'd10);
            return 7'd97 + CHAR_BITS'(d - 6'd36);
        endfunction

        // Divide repeatedly, then queue the remainders most significant
        // first. Zero spells as the single character '0'.
        function void spell_value(logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] q;
            logic [VALUE_BITS-1:0] b;
            logic [BASE_BITS-1:0]  digits[$];
            t_glyph                g;
            b = base_in_use();
            q = value;
            values_seen++;
            if (q == '0) begin
                g.ch  = CHAR_ZERO;
                g.fin = 1'b1;
                pending_glyphs.push_back(g);
                return;
            end
            while (q != '0) begin
                digits.push_front(BASE_BITS'(q % b));
                q = q / b;
            end
            foreach (digits[k]) begin
                g.ch  = glyph_of(digits[k]);
                g.fin = (k == digits.size() - 1);
                pending_glyphs.push_back(g);
            end
        endfunction

        task check_glyph(logic [CHAR_BITS-1:0] ch, logic fin);
            t_glyph want;
            chars_checked++;
            if (pending_glyphs.size() == 0) begin
                report($sformatf("character 0x%02h arrived with no string pending", ch));
                return;
            end
            want = pending_glyphs.pop_front();
            if (ch !== want.ch)
                report($sformatf("character 0x%02h, expected 0x%02h", ch, want.ch));
            if (fin !== want.fin)
                report($sformatf("last flag %b, expected %b on character 0x%02h",
                                 fin, want.fin, want.ch));
        endtask

        function int pending();
            return pending_glyphs.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [TDATA_IN_BITS-1:0]  s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [TDATA_OUT_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    radix_scoreboard sb;

    // Per-phase switches that turn off idling on the sender or receiver.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int stall_left = 0;
    int rx_gap;
    int quiet_cycles = 0;
    int radix_writes = 0;

    integer_to_radix_string DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Idle length: mostly none, often a few cycles, now and then a long
    // stretch so that a gap can land on any digit of a conversion.
    function automatic int pick_gap(bit steady);
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Random value with a spread of magnitudes: most are short so the run
    // stays fast, some use the full width, and a few are zero.
    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [63:0] raw;
        int          width;
        int          roll;
        raw  = {$urandom(), $urandom()};
        roll = $urandom_range(0, 99);
        if (roll < 3) return '0;
        if (roll < 65) width = $urandom_range(1, 20);
        else if (roll < 92) width = $urandom_range(21, 62);
        else width = VALUE_BITS;
        return raw[VALUE_BITS-1:0] & ((VALUE_BITS'(1) << width) - 1'b1);
    endfunction

    // Offers one value on the slave stream and holds it until it is taken.
    // With no gap the valid stays high from the previous beat.
    task automatic send_value(logic [VALUE_BITS-1:0] v);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_BITS'(v);
        do @(posedge i_clk); while (!s_axis_tready);
        sb.spell_value(v);
    endtask

    // Drops the valid and waits until every expected character has left.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Register write with a setup and an access phase; the block is idle whenever this is called.
    task automatic set_radix(logic [BASE_BITS-1:0] r);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RADIX;
        pwdata  <= APB_DATA_BITS'(r);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.radix_copy = r;
        radix_writes++;
    endtask

    task automatic random_phase(logic [BASE_BITS-1:0] r, bit calm);
        set_radix(r);
        tx_steady = calm;
        rx_steady = calm;
        repeat (RANDOM_PER_PHASE) send_value(rand_value());
        settle();
    endtask

    // Receiver: checks every accepted character and throttles tready with
    // random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_glyph(m_axis_tdata[CHAR_BITS-1:0], m_axis_tlast);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else begin
                rx_gap = (rx_steady || $urandom_range(0, 9) > 1) ? 0 : pick_gap(1'b0);
                if (rx_gap == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    stall_left    <= rx_gap - 1;
                end
            end
        end
    end

    // Watchdog: any beat on either stream restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles, %0d characters still expected",
                     HANG_LIMIT, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first in the reset base of ten: zero, single and
        // two-digit edges, and the largest values.
        send_value('0);
        send_value(63'd1);
        send_value(63'd9);
        send_value(63'd10);
        send_value(63'd99);
        send_value(63'd100);
        send_value({VALUE_BITS{1'b1}});
        send_value(63'h4000_0000_0000_0000);
        settle();

        // Base two: the longest strings, sixty-three characters.
        set_radix(6'd2);
        send_value('0);
        send_value(63'd1);
        send_value({VALUE_BITS{1'b1}});
        send_value(63'h4000_0000_0000_0000);
        settle();

        // Base sixty-two: the highest digit and carries into a new digit.
        set_radix(6'd62);
        send_value(63'd61);
        send_value(63'd62);
        send_value(63'd3843);
        send_value({VALUE_BITS{1'b1}});
        settle();

        // Base thirty-six: the upper end of the capital letters.
        set_radix(6'd36);
        send_value(63'd35);
        send_value(63'd1295);
        settle();

        // Out-of-range codes: 63 acts as base sixty-two, 0 and 1 as two.
        set_radix(6'd63);
        send_value(63'd61);
        settle();
        set_radix(6'd0);
        send_value(63'd5);
        settle();
        set_radix(6'd1);
        send_value(63'd2);
        settle();

        // Random part, one phase per radix code set; one phase runs without idling.
        random_phase(6'd2, 1'b0);
        random_phase(6'd62, 1'b0);
        random_phase(6'd16, 1'b1);
        random_phase(6'd0, 1'b0);
        random_phase(6'd63, 1'b0);
        random_phase(6'd7, 1'b0);
        random_phase(6'($urandom_range(2, 61)), 1'b0);
        random_phase(6'd10, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d values into %0d characters across %0d radix writes,",
                 sb.values_seen, sb.chars_checked, radix_writes);
        $display("covering bases two to sixty-two, saturated codes and zero input.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
